>>> design/mlft_pkg.sv
package mlft_pkg;

	// table and field geometry
	localparam int TABLE_DEPTH = 64;
	localparam int NUM_PORTS   = 8;
	localparam int MAC_W       = 48;
	localparam int PORT_W      = 3;
	localparam int MASK_W      = 8;
	localparam int CFG_W       = 4;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	// stream packing
	localparam int IN_FIELDS_W  = 2 * MAC_W + PORT_W;
	localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int RES_W        = MASK_W + 3;
	localparam int OUT_DATA_W   = ((RES_W + 7) / 8) * 8;

	localparam logic [CFG_W-1:0] PORT_COUNT_RST = CFG_W'(8);

	// item kinds
	localparam logic KIND_FRAME = 1'b0;
	localparam logic KIND_CLEAR = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_HOLD
	} ctl_state_t;

	// lookup token walking down the cell chain
	typedef struct packed {
		logic              vld;
		logic              kind;
		logic [MAC_W-1:0]  src_mac;
		logic [MAC_W-1:0]  dst_mac;
		logic [PORT_W-1:0] ingress_port;
		logic              src_hit;
		logic              dst_hit;
		logic [PORT_W-1:0] dst_port;
	} token_t;

	// entry write bus shared by all cells
	typedef struct packed {
		logic [MAC_W-1:0]  mac;
		logic [PORT_W-1:0] port;
	} entry_wr_t;

	// one result, egress mask in the low bits
	typedef struct packed {
		logic              table_full;
		logic              learned;
		logic              flooded;
		logic [MASK_W-1:0] egress_mask;
	} result_t;

	// all connected ports but the ingress one
	function automatic logic [MASK_W-1:0] flood_mask(input logic [CFG_W-1:0] cnt,
			input logic [PORT_W-1:0] ingress);
		logic [MASK_W-1:0] m;
		m = '0;
		for (int p = 0; p < MASK_W; p++) begin
			m[p] = (p < NUM_PORTS) && (p < int'(cnt)) && (PORT_W'(p) != ingress);
		end
		return m;
	endfunction

endpackage

>>> design/mlft_cell.sv
module mlft_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  mlft_pkg::token_t   tok_in,
	output mlft_pkg::token_t   tok_out,
	input  mlft_pkg::entry_wr_t wr,
	input  logic               wr_en,
	input  logic               clr
);
	import mlft_pkg::*;

	logic [MAC_W-1:0]  mac_q;
	logic [PORT_W-1:0] port_q;
	logic              valid_q;
	logic              tok_vld_q;
	token_t            tok_d;
	token_t            tok_q;
	logic              src_match;
	logic              dst_match;

	// compare the passing token against this entry
	assign src_match = valid_q && (mac_q == tok_in.src_mac);
	assign dst_match = valid_q && (mac_q == tok_in.dst_mac);

	// entry valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (clr) begin
			valid_q <= 1'b0;
		end else if (wr_en) begin
			valid_q <= 1'b1;
		end
	end

	// entry contents
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mac_q  <= wr.mac;
			port_q <= wr.port;
		end
	end

	// token valid toward the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_vld_q <= 1'b0;
		end else begin
			tok_vld_q <= tok_in.vld;
		end
	end

	// token payload with accumulated hits
	always_comb begin
		tok_d          = tok_in;
		tok_d.src_hit  = tok_in.src_hit | src_match;
		tok_d.dst_hit  = tok_in.dst_hit | dst_match;
		tok_d.dst_port = dst_match ? port_q : tok_in.dst_port;
	end

	always_ff @(posedge clk) begin
		tok_q <= tok_d;
	end

	always_comb begin
		tok_out     = tok_q;
		tok_out.vld = tok_vld_q;
	end

endmodule

>>> design/mac_learning_forwarding_table.sv
// path: the token passes the TABLE_DEPTH cell registers, then the output register
// flow: one item in flight at a time; the lookup token walks the
//   cell chain one entry per cycle and the next item waits for it to leave
// results sit in an output register; a pending register takes one more in a stall
// reset: table empty, port_count = 8, no result pending; entries need no clearing
module mac_learning_forwarding_table (
	input  logic                              clk,
	input  logic                              arst_n,
	// src_mac [47:0], dst_mac [95:48], ingress_port [98:96], zero pad
	input  logic [mlft_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	// kind
	input  logic                              s_axis_tuser,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// egress_mask [7:0], flooded [8], learned [9], table_full [10], zero pad
	output logic [mlft_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	input  logic                              cfg_wr_en,
	input  logic [mlft_pkg::CFG_W-1:0]        cfg_wr_data
);
	import mlft_pkg::*;

	ctl_state_t        state_q, state_d;
	logic [CFG_W-1:0]  port_count_q;
	logic [CNT_W-1:0]  count_q;
	logic              out_vld_q;
	result_t           out_q;
	result_t           pend_q;
	result_t           res;
	token_t            inj_tok;
	token_t            chain_tok [TABLE_DEPTH];
	token_t            last_tok;
	entry_wr_t         wr;
	logic [TABLE_DEPTH-1:0] wr_en;
	logic              accept;
	logic              out_take;
	logic              done;
	logic              new_src;
	logic              learn;
	logic              clr_all;
	logic              load_out_res;
	logic              load_out_pend;
	logic              load_pend;

	assign accept   = s_axis_tvalid && s_axis_tready;
	assign out_take = out_vld_q && m_axis_tready;

	// token entering the first cell
	always_comb begin
		inj_tok              = '0;
		inj_tok.vld          = accept;
		inj_tok.kind         = s_axis_tuser;
		inj_tok.src_mac      = s_axis_tdata[MAC_W-1:0];
		inj_tok.dst_mac      = s_axis_tdata[2*MAC_W-1:MAC_W];
		inj_tok.ingress_port = s_axis_tdata[2*MAC_W+PORT_W-1:2*MAC_W];
	end

	// commit at the end of the chain
	assign last_tok = chain_tok[TABLE_DEPTH-1];
	assign done     = last_tok.vld;
	assign new_src  = done && (last_tok.kind == KIND_FRAME) && !last_tok.src_hit;
	assign learn    = new_src && (count_q < CNT_W'(TABLE_DEPTH));
	assign clr_all  = done && (last_tok.kind == KIND_CLEAR);
	assign wr.mac   = last_tok.src_mac;
	assign wr.port  = last_tok.ingress_port;

	// cell chain with its write decode
	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		assign wr_en[i] = learn && (count_q[IDX_W-1:0] == IDX_W'(i));
		if (i == 0) begin : g_head
			mlft_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.tok_in (inj_tok),
				.tok_out(chain_tok[i]),
				.wr     (wr),
				.wr_en  (wr_en[i]),
				.clr    (clr_all)
			);
		end else begin : g_body
			mlft_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.tok_in (chain_tok[i-1]),
				.tok_out(chain_tok[i]),
				.wr     (wr),
				.wr_en  (wr_en[i]),
				.clr    (clr_all)
			);
		end
	end

	// forwarding decision
	always_comb begin
		res = '0;
		if (last_tok.kind == KIND_FRAME) begin
			res.learned    = learn;
			res.table_full = new_src && !learn;
			if (&last_tok.dst_mac) begin
				res.egress_mask = flood_mask(port_count_q, last_tok.ingress_port);
				res.flooded     = 1'b1;
			end else if (last_tok.dst_hit) begin
				res.egress_mask = MASK_W'(1) << last_tok.dst_port;
			end else if (learn && (last_tok.dst_mac == last_tok.src_mac)) begin
				res.egress_mask = MASK_W'(1) << last_tok.ingress_port;
			end else begin
				res.egress_mask = flood_mask(port_count_q, last_tok.ingress_port);
				res.flooded     = 1'b1;
			end
		end
	end

	// control state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and load strobes
	always_comb begin
		state_d       = state_q;
		load_out_res  = 1'b0;
		load_out_pend = 1'b0;
		load_pend     = 1'b0;
		s_axis_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					state_d = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				if (done) begin
					if (!out_vld_q || out_take) begin
						load_out_res = 1'b1;
						state_d      = ST_IDLE;
					end else begin
						load_pend = 1'b1;
						state_d   = ST_HOLD;
					end
				end
			end
			ST_HOLD: begin
				if (out_take) begin
					load_out_pend = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// entry count and port count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			port_count_q <= PORT_COUNT_RST;
		end else begin
			if (clr_all) begin
				count_q <= '0;
			end else if (learn) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (cfg_wr_en) begin
				port_count_q <= cfg_wr_data;
			end
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (load_out_res || load_out_pend) begin
			out_vld_q <= 1'b1;
		end else if (out_take) begin
			out_vld_q <= 1'b0;
		end
	end

	// output and pending result payload
	always_ff @(posedge clk) begin
		if (load_out_res) begin
			out_q <= res;
		end else if (load_out_pend) begin
			out_q <= pend_q;
		end
		if (load_pend) begin
			pend_q <= res;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {{(OUT_DATA_W - RES_W){1'b0}}, out_q};

endmodule

>>> design/mlft_checker.sv
module mlft_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic [mlft_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	input logic                            s_axis_tuser,
	input logic                            s_axis_tvalid,
	input logic                            s_axis_tready,
	input logic [mlft_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic                            cfg_wr_en,
	input logic [mlft_pkg::CFG_W-1:0]      cfg_wr_data
);
	import mlft_pkg::*;

	result_t res;

	assign res = result_t'(m_axis_tdata[RES_W-1:0]);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// one item in the chain at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("second item taken while lookup in flight");

	// learned and full never together
	a_learn_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(res.learned && res.table_full))
		else $error("learned and table_full both set");

	// a result that is not flooded goes to at most a single port
	a_unicast: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !res.flooded |-> $onehot0(res.egress_mask))
		else $error("unicast result with several ports");

endmodule

bind mac_learning_forwarding_table mlft_checker u_mlft_checker (.*);
